// ===== src/page_region_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// page region allocator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PAGE_REGION_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_REGION_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PRA_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pra assertion failed");

// next-cycle implication
`define PRA_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pra assertion failed");

`endif

// ===== src/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// types and codes shared by the page region allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    localparam int PAGE_W  = 21;
    localparam int BYTES_W = 33;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FIT    = 2'd1,
        STATUS_NOT_START = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] request_bytes;
        logic [63:0] address;
    } req_t;

    typedef struct packed {
        logic [63:0]        result_address;
        logic [BYTES_W-1:0] extent_bytes;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic              used;
        logic              free;
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] pages;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/pra_table.sv =====
// ----------------------------------------------------------------------------
// pra_table
// extent table memory, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pra_table
    import pra_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [IW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [IW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/page_region_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_region_allocator_unit
// best-fit page extent allocator with coalescing over a table in memory
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on in_valid/in_ready with in_data, results leave on
//   out_valid/out_ready with out_data, one result per request transaction.
//   the table is one memory read one entry a cycle; every request but a
//   zero-size allocate or an unused func makes one pass over all
//   MAX_EXTENTS entries, and a free of an allocated extent makes a second
//   pass for its neighbors; one request is in work at a time.
//   region_base (0x0) and region_pages (0x8) are written over the apb port;
//   a write, and reset, start a clearing pass over all MAX_EXTENTS entries that
//   leaves one free extent covering the region, with in_ready low meanwhile.
//   the result sits in an output register: a new request is taken while it
//   waits, and that request finishes only once the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module page_region_allocator_unit
    import pra_pkg::*;
#(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_SHIFT  = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire req_t        in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rsp_t             out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

`include "page_region_allocator_unit_assert.svh"

    localparam int IW    = $clog2(MAX_EXTENTS);
    localparam int CNT_W = IW + 1;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_EXTENTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_EXTENTS - 1);
    localparam logic [63:0] BYTES_MAX = 64'h1_FFFF_FFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_EVAL,
        ST_ALLOC_WR_SLOT,
        ST_ALLOC_WR_BEST,
        ST_ADDR,
        ST_FREE_SCAN,
        ST_FREE_WR_NEXT,
        ST_FREE_WR_K,
        ST_FREE_WR_PREV,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IW-1:0]      pidx_reg;
    logic [63:0]        base_reg;
    logic [PAGE_W-1:0]  pages_reg;
    logic               out_valid_reg;
    rsp_t               out_data_reg;

    logic [1:0]         func_reg;
    logic [32:0]        need_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               page_ok_reg;

    logic               best_found_reg;
    logic [IW-1:0]      best_idx_reg;
    entry_t             best_reg;
    logic               slot_found_reg;
    logic [IW-1:0]      slot_idx_reg;
    logic               k_found_reg;
    logic [IW-1:0]      k_idx_reg;
    entry_t             k_reg;
    logic               next_found_reg;
    logic [IW-1:0]      next_idx_reg;
    logic [PAGE_W-1:0]  next_pages_reg;
    logic               prev_found_reg;
    logic [IW-1:0]      prev_idx_reg;
    entry_t             prev_reg;
    logic [PAGE_W-1:0]  kp_reg;

    logic [63:0]        res_addr_reg;
    logic [BYTES_W-1:0] res_bytes_reg;
    status_t            res_status_reg;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    entry_t             mem_wdata;
    entry_t             rdata;

    logic               cfg_wr;
    logic               out_load;
    logic [63:0]        in_diff;
    logic [63:0]        in_page;
    logic [32:0]        in_need;
    logic               scan_data;

    function automatic logic [BYTES_W-1:0] page_bytes(input logic [PAGE_W-1:0] p);
        logic [63:0] w;
        w = {{(64 - PAGE_W){1'b0}}, p} << PAGE_SHIFT;
        return (w > BYTES_MAX) ? {BYTES_W{1'b1}} : w[BYTES_W-1:0];
    endfunction

    pra_table #(
        .DEPTH (MAX_EXTENTS),
        .IW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = paddr[3] ? {{(64 - PAGE_W){1'b0}}, pages_reg} : base_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = !cfg_wr && (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign in_diff   = in_data.address - base_reg;
    assign in_page   = in_diff >> PAGE_SHIFT;
    assign in_need   = ({1'b0, in_data.request_bytes} + 33'((64'd1 << PAGE_SHIFT) - 64'd1))
                       >> PAGE_SHIFT;
    assign scan_data = (cnt_reg != '0);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[IW-1:0];
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (cnt_reg == '0)
                begin
                    mem_wdata = '{used: 1'b1, free: 1'b1, start: '0, pages: pages_reg};
                end
            end
            ST_ALLOC_WR_SLOT:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_idx_reg;
                mem_wdata = '{used: 1'b1, free: 1'b1,
                              start: best_reg.start + need_reg[PAGE_W-1:0],
                              pages: best_reg.pages - need_reg[PAGE_W-1:0]};
            end
            ST_ALLOC_WR_BEST:
            begin
                mem_we    = 1'b1;
                mem_waddr = best_idx_reg;
                mem_wdata = '{used: 1'b1, free: 1'b0, start: best_reg.start,
                              pages: need_reg[PAGE_W-1:0]};
            end
            ST_FREE_WR_NEXT:
            begin
                mem_we    = next_found_reg;
                mem_waddr = next_idx_reg;
            end
            ST_FREE_WR_K:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_idx_reg;
                if (!prev_found_reg)
                begin
                    mem_wdata = '{used: 1'b1, free: 1'b1, start: k_reg.start, pages: kp_reg};
                end
            end
            ST_FREE_WR_PREV:
            begin
                mem_we    = prev_found_reg;
                mem_waddr = prev_idx_reg;
                mem_wdata = '{used: 1'b1, free: 1'b1, start: prev_reg.start,
                              pages: prev_reg.pages + kp_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            base_reg      <= '0;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pidx_reg <= cnt_reg[IW-1:0];
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                if (paddr[3])
                begin
                    pages_reg <= pwdata[PAGE_W-1:0];
                end
                else
                begin
                    base_reg <= pwdata;
                end
                cnt_reg   <= '0;
                state_reg <= ST_CLEAR;
            end
            else
            begin
                case (state_reg)
                    ST_CLEAR:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (in_valid)
                        begin
                            func_reg       <= in_data.func;
                            need_reg       <= in_need;
                            page_reg       <= in_page[PAGE_W-1:0];
                            page_ok_reg    <= (in_page[63:PAGE_W] == '0);
                            best_found_reg <= 1'b0;
                            slot_found_reg <= 1'b0;
                            k_found_reg    <= 1'b0;
                            next_found_reg <= 1'b0;
                            prev_found_reg <= 1'b0;
                            res_addr_reg   <= '0;
                            res_bytes_reg  <= '0;
                            res_status_reg <= STATUS_OK;
                            cnt_reg        <= '0;
                            if (in_data.func == FUNC_NONE)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else if (in_data.func == FUNC_ALLOC && in_need == '0)
                            begin
                                res_status_reg <= STATUS_NO_FIT;
                                state_reg      <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_FIND;
                            end
                        end
                    end
                    ST_FIND:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (scan_data)
                        begin
                            if (func_reg == FUNC_ALLOC)
                            begin
                                if (!rdata.used)
                                begin
                                    if (!slot_found_reg)
                                    begin
                                        slot_found_reg <= 1'b1;
                                        slot_idx_reg   <= pidx_reg;
                                    end
                                end
                                else if (rdata.free &&
                                         {12'd0, rdata.pages} >= need_reg &&
                                         (!best_found_reg ||
                                          rdata.pages < best_reg.pages ||
                                          (rdata.pages == best_reg.pages &&
                                           rdata.start < best_reg.start)))
                                begin
                                    best_found_reg <= 1'b1;
                                    best_idx_reg   <= pidx_reg;
                                    best_reg       <= rdata;
                                end
                            end
                            else if (!k_found_reg && rdata.used && page_ok_reg &&
                                     rdata.start == page_reg)
                            begin
                                k_found_reg <= 1'b1;
                                k_idx_reg   <= pidx_reg;
                                k_reg       <= rdata;
                            end
                        end
                        if (cnt_reg == CNT_END)
                        begin
                            state_reg <= ST_EVAL;
                        end
                    end
                    ST_EVAL:
                    begin
                        cnt_reg <= '0;
                        if (func_reg == FUNC_ALLOC)
                        begin
                            if (!best_found_reg)
                            begin
                                res_status_reg <= STATUS_NO_FIT;
                                state_reg      <= ST_DONE;
                            end
                            else if ({12'd0, best_reg.pages} != need_reg)
                            begin
                                if (!slot_found_reg)
                                begin
                                    res_status_reg <= STATUS_FULL;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_ALLOC_WR_SLOT;
                                end
                            end
                            else
                            begin
                                state_reg <= ST_ALLOC_WR_BEST;
                            end
                        end
                        else if (!k_found_reg)
                        begin
                            res_status_reg <= STATUS_NOT_START;
                            state_reg      <= ST_DONE;
                        end
                        else if (func_reg == FUNC_QUERY)
                        begin
                            res_bytes_reg <= page_bytes(k_reg.pages);
                            state_reg     <= ST_DONE;
                        end
                        else if (k_reg.free)
                        begin
                            res_status_reg <= STATUS_NOT_START;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_FREE_SCAN;
                        end
                    end
                    ST_ALLOC_WR_SLOT:
                    begin
                        state_reg <= ST_ALLOC_WR_BEST;
                    end
                    ST_ALLOC_WR_BEST:
                    begin
                        state_reg <= ST_ADDR;
                    end
                    ST_ADDR:
                    begin
                        res_addr_reg  <= base_reg +
                                         ({{(64 - PAGE_W){1'b0}}, best_reg.start} << PAGE_SHIFT);
                        res_bytes_reg <= page_bytes(need_reg[PAGE_W-1:0]);
                        state_reg     <= ST_DONE;
                    end
                    ST_FREE_SCAN:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (scan_data && pidx_reg != k_idx_reg && rdata.used && rdata.free)
                        begin
                            if ({1'b0, rdata.start} + {1'b0, rdata.pages} ==
                                {1'b0, k_reg.start})
                            begin
                                prev_found_reg <= 1'b1;
                                prev_idx_reg   <= pidx_reg;
                                prev_reg       <= rdata;
                            end
                            else if ({1'b0, rdata.start} ==
                                     {1'b0, k_reg.start} + {1'b0, k_reg.pages})
                            begin
                                next_found_reg <= 1'b1;
                                next_idx_reg   <= pidx_reg;
                                next_pages_reg <= rdata.pages;
                            end
                        end
                        if (cnt_reg == CNT_END)
                        begin
                            state_reg <= ST_FREE_WR_NEXT;
                        end
                    end
                    ST_FREE_WR_NEXT:
                    begin
                        kp_reg    <= next_found_reg ? k_reg.pages + next_pages_reg : k_reg.pages;
                        state_reg <= ST_FREE_WR_K;
                    end
                    ST_FREE_WR_K:
                    begin
                        state_reg <= ST_FREE_WR_PREV;
                    end
                    ST_FREE_WR_PREV:
                    begin
                        state_reg <= ST_DONE;
                    end
                    ST_DONE:
                    begin
                        if (out_load)
                        begin
                            out_data_reg  <= '{result_address: res_addr_reg,
                                               extent_bytes: res_bytes_reg,
                                               status: res_status_reg};
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    `PRA_ASSERT_IMP(a_no_write_in_scan, state_reg == ST_FIND || state_reg == ST_FREE_SCAN, !mem_we)
    `PRA_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready && !cfg_wr, state_reg != ST_IDLE)
    `PRA_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE))

endmodule

`default_nettype wire
